### hdl/sompbm_pkg.sv
// Shared types and fixed constants of the SOM best match query block.
`timescale 1ns / 1ps

package sompbm_pkg;

   // fixed port widths
   localparam int FIELD_BITS      = 16;
   localparam int POS_FIELD_BITS  = 4;
   localparam int WIDX_BITS       = 2;
   localparam int DIST_BITS       = 34;
   localparam int QUERY_FIELDS    = 4;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // configuration registers
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;
   localparam int SIDE_CFG_BITS  = 5;
   localparam int FEAT_SEL_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_SIDE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIRST_FEATURE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LAST_FEATURE  = 2'd2;

   localparam logic [SIDE_CFG_BITS-1:0] GRID_SIDE_RESET     = 5'd16;
   localparam logic [FEAT_SEL_BITS-1:0] FIRST_FEATURE_RESET = 2'd0;
   localparam logic [FEAT_SEL_BITS-1:0] LAST_FEATURE_RESET  = 2'd3;

   // marker travelling with each node through the distance pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

### hdl/sompbm_dist.sv
// Two-stage squared distance pipeline: per-feature squares, then their sum.
`timescale 1ns / 1ps

module sompbm_dist
   import sompbm_pkg::*;
#(
   parameter int FEATURES  = 4,
   parameter int VAL_BITS  = 16,
   parameter int SUM_BITS  = 34,
   parameter int INFO_BITS = 72
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tag_type                      in_tag,
   input  logic [INFO_BITS-1:0]         in_info,
   input  logic [FEATURES*VAL_BITS-1:0] in_query,
   input  logic [FEATURES*VAL_BITS-1:0] in_weights,
   input  logic [FEATURES-1:0]          in_incl,
   output tag_type                      out_tag,
   output logic [INFO_BITS-1:0]         out_info,
   output logic [SUM_BITS-1:0]          out_sum
);

   localparam int DIFF_BITS = VAL_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int SQ_BITS   = 2 * VAL_BITS;

   logic signed [DIFF_BITS-1:0] diff [FEATURES];
   logic signed [PROD_BITS-1:0] prod [FEATURES];
   logic        [SQ_BITS-1:0]   sq_in [FEATURES];
   logic        [SQ_BITS-1:0]   sq_ff [FEATURES];
   logic        [SUM_BITS-1:0]  sum_in;
   logic        [SUM_BITS-1:0]  sum_ff;
   tag_type                     tag_a_ff;
   tag_type                     tag_b_ff;
   logic        [INFO_BITS-1:0] info_a_ff;
   logic        [INFO_BITS-1:0] info_b_ff;

   // squares of the differences, features outside the range count as zero
   always_comb begin
      for (int f = 0; f < FEATURES; f++) begin
         diff[f] = DIFF_BITS'(signed'(in_query[f*VAL_BITS +: VAL_BITS]))
                 - DIFF_BITS'(signed'(in_weights[f*VAL_BITS +: VAL_BITS]));
         prod[f] = diff[f] * diff[f];
         sq_in[f] = in_incl[f] ? SQ_BITS'(prod[f]) : '0;
      end
   end

   // sum of the registered squares
   always_comb begin
      sum_in = '0;
      for (int f = 0; f < FEATURES; f++) begin
         sum_in = sum_in + SUM_BITS'(sq_ff[f]);
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      info_a_ff <= in_info;
      sum_ff    <= sum_in;
      info_b_ff <= info_a_ff;
   end

   // marker stages
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
      end else begin
         tag_a_ff <= in_tag;
         tag_b_ff <= tag_a_ff;
      end
   end

   assign out_tag  = tag_b_ff;
   assign out_info = info_b_ff;
   assign out_sum  = sum_ff;

endmodule

### hdl/som_partial_best_match_query.sv
// Best matching node search over a weight memory of self-organizing map nodes.
// A load word writes one weight; busy stays low.
// A query scans side*side nodes, one memory read per cycle, and shows its result
// once the last node has left the distance pipeline; busy falls in the same cycle,
// so the next word can be taken while the result is shown.
// Synchronous reset restores the registers to 16/0/3; weights stay undefined until loaded.
`timescale 1ns / 1ps

module som_partial_best_match_query
   import sompbm_pkg::*;
#(
   parameter int MAX_GRID_SIDE = 16,
   parameter int FEATURES      = 4,
   parameter int WEIGHT_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic        [POS_FIELD_BITS-1:0] req_node_row,
   input  logic        [POS_FIELD_BITS-1:0] req_node_col,
   input  logic        [WIDX_BITS-1:0]      req_weight_index,
   input  logic signed [FIELD_BITS-1:0]     req_weight_value,
   input  logic signed [FIELD_BITS-1:0]     req_query_feature_0,
   input  logic signed [FIELD_BITS-1:0]     req_query_feature_1,
   input  logic signed [FIELD_BITS-1:0]     req_query_feature_2,
   input  logic signed [FIELD_BITS-1:0]     req_query_feature_3,
   // result channel
   output logic                            rsp_valid,
   output logic        [POS_FIELD_BITS-1:0] rsp_best_row,
   output logic        [POS_FIELD_BITS-1:0] rsp_best_col,
   output logic signed [FIELD_BITS-1:0]     rsp_best_feature_0,
   output logic signed [FIELD_BITS-1:0]     rsp_best_feature_1,
   output logic signed [FIELD_BITS-1:0]     rsp_best_feature_2,
   output logic signed [FIELD_BITS-1:0]     rsp_best_feature_3,
   output logic        [DIST_BITS-1:0]      rsp_best_distance_sq,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int VAL_BITS  = (WEIGHT_BITS < FIELD_BITS) ? WEIGHT_BITS : FIELD_BITS;
   localparam int W_BITS    = FEATURES * VAL_BITS;
   localparam int NODES     = MAX_GRID_SIDE * MAX_GRID_SIDE;
   localparam int ADDR_BITS = $clog2(NODES);
   localparam int POS_BITS  = $clog2(MAX_GRID_SIDE);
   localparam int SIDE_BITS = $clog2(MAX_GRID_SIDE + 1);
   localparam int SUM_BITS  = 2 * VAL_BITS + $clog2(FEATURES);
   localparam int INFO_BITS = 2 * POS_BITS + W_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // configuration registers
   logic [SIDE_CFG_BITS-1:0] grid_side_ff;
   logic [FEAT_SEL_BITS-1:0] first_ff;
   logic [FEAT_SEL_BITS-1:0] last_ff;

   // control
   logic [1:0]          state_ff, state_in;
   logic [POS_BITS-1:0] row_ff, row_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic                have_ff, have_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // query context
   logic [W_BITS-1:0]    query_ff, query_in;
   logic [FEATURES-1:0]  incl_ff, incl_in;
   logic [POS_BITS-1:0]  last_pos_ff, last_pos_in;
   logic [SIDE_BITS-1:0] side;

   // memory and read stage
   logic [W_BITS-1:0]    mem [NODES];
   logic [W_BITS-1:0]    rdata_ff;
   logic [ADDR_BITS-1:0] raddr;
   logic [ADDR_BITS-1:0] waddr;
   logic                 rd_en;
   logic                 load_we;
   tag_type              tag0;
   tag_type              tag1_ff;
   logic [POS_BITS-1:0]  row1_ff;
   logic [POS_BITS-1:0]  col1_ff;

   // distance pipeline output
   tag_type              d_tag;
   logic [INFO_BITS-1:0] d_info;
   logic [SUM_BITS-1:0]  d_sum;
   logic                 take;

   // best candidate
   logic [POS_BITS-1:0] best_row_ff;
   logic [POS_BITS-1:0] best_col_ff;
   logic [W_BITS-1:0]   best_w_ff;
   logic [SUM_BITS-1:0] best_dist_ff;

   logic [FIELD_BITS-1:0] qport [QUERY_FIELDS];

   logic accept;
   logic q_accept;

   assign accept    = start && !busy;
   assign q_accept  = accept && (req_kind == KIND_QUERY);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= GRID_SIDE_RESET;
         first_ff     <= FIRST_FEATURE_RESET;
         last_ff      <= LAST_FEATURE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GRID_SIDE:     grid_side_ff <= SIDE_CFG_BITS'(csr_wdata);
            REG_FIRST_FEATURE: first_ff     <= FEAT_SEL_BITS'(csr_wdata);
            REG_LAST_FEATURE:  last_ff      <= FEAT_SEL_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   // query features at the value width, missing ones are zero
   assign qport[0] = req_query_feature_0;
   assign qport[1] = req_query_feature_1;
   assign qport[2] = req_query_feature_2;
   assign qport[3] = req_query_feature_3;

   for (genvar f = 0; f < FEATURES; f++) begin : g_query
      if (f < QUERY_FIELDS) begin : g_field
         assign query_in[f*VAL_BITS +: VAL_BITS] = VAL_BITS'(qport[f]);
      end else begin : g_zero
         assign query_in[f*VAL_BITS +: VAL_BITS] = '0;
      end
   end

   // grid side clamped to 1..MAX_GRID_SIDE, feature range mask
   always_comb begin
      if (grid_side_ff == '0) begin
         side = SIDE_BITS'(1);
      end else if (int'(grid_side_ff) > MAX_GRID_SIDE) begin
         side = SIDE_BITS'(MAX_GRID_SIDE);
      end else begin
         side = SIDE_BITS'(grid_side_ff);
      end
      last_pos_in = POS_BITS'(side - SIDE_BITS'(1));
      for (int f = 0; f < FEATURES; f++) begin
         incl_in[f] = (f >= int'(first_ff)) && (f <= int'(last_ff));
      end
   end

   // scan sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      have_in      = have_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_accept) begin
               state_in = ST_SCAN;
               row_in   = '0;
               col_in   = '0;
               have_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (col_ff == last_pos_ff) begin
               col_in = '0;
               if (row_ff == last_pos_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + POS_BITS'(1);
               end
            end else begin
               col_in = col_ff + POS_BITS'(1);
            end
         end
         ST_DRAIN: ;
         default: state_in = ST_IDLE;
      endcase
      if (take) begin
         have_in = 1'b1;
      end
      if (d_tag.valid && d_tag.last) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // query context held for the whole scan
   always_ff @(posedge clock) begin
      if (q_accept) begin
         query_ff    <= query_in;
         incl_ff     <= incl_in;
         last_pos_ff <= last_pos_in;
      end
   end

   // weight memory: lane write on load, one node read per scan cycle
   assign load_we = accept && (req_kind == KIND_LOAD)
                 && (int'(req_node_row) < MAX_GRID_SIDE)
                 && (int'(req_node_col) < MAX_GRID_SIDE)
                 && (int'(req_weight_index) < FEATURES);
   assign waddr = ADDR_BITS'(POS_BITS'(req_node_row)) * ADDR_BITS'(MAX_GRID_SIDE)
                + ADDR_BITS'(POS_BITS'(req_node_col));
   assign raddr = ADDR_BITS'(row_ff) * ADDR_BITS'(MAX_GRID_SIDE) + ADDR_BITS'(col_ff);
   assign rd_en = (state_ff == ST_SCAN);

   always_ff @(posedge clock) begin
      for (int f = 0; f < FEATURES; f++) begin
         if (load_we && (int'(req_weight_index) == f)) begin
            mem[waddr][f*VAL_BITS +: VAL_BITS] <= VAL_BITS'(req_weight_value);
         end
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // node position and marker alongside the read
   assign tag0.valid = rd_en;
   assign tag0.last  = (row_ff == last_pos_ff) && (col_ff == last_pos_ff);

   always_ff @(posedge clock) begin
      row1_ff <= row_ff;
      col1_ff <= col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else begin
         tag1_ff <= tag0;
      end
   end

   sompbm_dist #(
      .FEATURES  (FEATURES),
      .VAL_BITS  (VAL_BITS),
      .SUM_BITS  (SUM_BITS),
      .INFO_BITS (INFO_BITS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (tag1_ff),
      .in_info    ({row1_ff, col1_ff, rdata_ff}),
      .in_query   (query_ff),
      .in_weights (rdata_ff),
      .in_incl    (incl_ff),
      .out_tag    (d_tag),
      .out_info   (d_info),
      .out_sum    (d_sum)
   );

   // strictly smaller sum wins, first node always taken
   assign take = d_tag.valid && (!have_ff || (d_sum < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_row_ff  <= d_info[INFO_BITS-1 -: POS_BITS];
         best_col_ff  <= d_info[INFO_BITS-POS_BITS-1 -: POS_BITS];
         best_w_ff    <= d_info[W_BITS-1:0];
         best_dist_ff <= d_sum;
      end
   end

   // result word
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_best_row         = POS_FIELD_BITS'(best_row_ff);
   assign rsp_best_col         = POS_FIELD_BITS'(best_col_ff);
   assign rsp_best_distance_sq = DIST_BITS'(best_dist_ff);

   logic [FIELD_BITS-1:0] best_feat [QUERY_FIELDS];

   for (genvar k = 0; k < QUERY_FIELDS; k++) begin : g_best
      if (k < FEATURES) begin : g_weight
         assign best_feat[k] = FIELD_BITS'(signed'(best_w_ff[k*VAL_BITS +: VAL_BITS]));
      end else begin : g_zero
         assign best_feat[k] = '0;
      end
   end

   assign rsp_best_feature_0 = best_feat[0];
   assign rsp_best_feature_1 = best_feat[1];
   assign rsp_best_feature_2 = best_feat[2];
   assign rsp_best_feature_3 = best_feat[3];

endmodule

### dv/som_partial_best_match_query_tb.sv
// Self-checking testbench for the SOM best matching node query block.
`timescale 1ns / 1ps

module som_partial_best_match_query_tb
   import sompbm_pkg::*;
();

   localparam int GRID_MAX       = 16;
   localparam int TIMEOUT_CYCLES = 600_000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 200;

   // unused register slot, writes to it must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   typedef logic signed [FIELD_BITS-1:0] q88_type;
   typedef q88_type [QUERY_FIELDS-1:0] feat_vec_type;

   typedef struct packed {
      logic [POS_FIELD_BITS-1:0] row;
      logic [POS_FIELD_BITS-1:0] col;
      feat_vec_type              feat;
      logic [DIST_BITS-1:0]      dist_sq;
   } best_match_type;

   typedef enum logic [1:0] {STEP_LOAD, STEP_QUERY, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type             kind;
      logic [POS_FIELD_BITS-1:0] row;
      logic [POS_FIELD_BITS-1:0] col;
      logic [WIDX_BITS-1:0]      widx;
      q88_type                   value;
      feat_vec_type              query;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [CSR_DATA_BITS-1:0]  csr_data;
      bit                        pinned;
      best_match_type            result;
   } stim_step_type;

   // opposite corners of the Q8.8 range, giving the largest possible distance
   localparam feat_vec_type CORNER_W = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
   localparam feat_vec_type FAR_Q    = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};

   logic clock;
   logic reset = 1'b1;

   logic                             start = 1'b0;
   logic                             busy;
   logic                             req_kind = KIND_LOAD;
   logic        [POS_FIELD_BITS-1:0] req_node_row = '0;
   logic        [POS_FIELD_BITS-1:0] req_node_col = '0;
   logic        [WIDX_BITS-1:0]      req_weight_index = '0;
   logic signed [FIELD_BITS-1:0]     req_weight_value = '0;
   logic signed [FIELD_BITS-1:0]     req_query_feature_0 = '0;
   logic signed [FIELD_BITS-1:0]     req_query_feature_1 = '0;
   logic signed [FIELD_BITS-1:0]     req_query_feature_2 = '0;
   logic signed [FIELD_BITS-1:0]     req_query_feature_3 = '0;
   logic                             rsp_valid;
   logic        [POS_FIELD_BITS-1:0] rsp_best_row;
   logic        [POS_FIELD_BITS-1:0] rsp_best_col;
   logic signed [FIELD_BITS-1:0]     rsp_best_feature_0;
   logic signed [FIELD_BITS-1:0]     rsp_best_feature_1;
   logic signed [FIELD_BITS-1:0]     rsp_best_feature_2;
   logic signed [FIELD_BITS-1:0]     rsp_best_feature_3;
   logic        [DIST_BITS-1:0]      rsp_best_distance_sq;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic        [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic        [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // typed expectation travelling with the word being offered
   logic           pinned_flag = 1'b0;
   best_match_type pinned_match = '0;

   // mirror of the block: weight memory and registers
   feat_vec_type              node_weight [GRID_MAX*GRID_MAX];
   logic [SIDE_CFG_BITS-1:0]  grid_side_cfg;
   logic [FEAT_SEL_BITS-1:0]  first_feat_cfg;
   logic [FEAT_SEL_BITS-1:0]  last_feat_cfg;

   best_match_type pending_matches [$];
   stim_step_type  dir_steps [$];
   int             mismatch_count = 0;
   int             idle_pct = 0;

   som_partial_best_match_query dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_node_row         (req_node_row),
      .req_node_col         (req_node_col),
      .req_weight_index     (req_weight_index),
      .req_weight_value     (req_weight_value),
      .req_query_feature_0  (req_query_feature_0),
      .req_query_feature_1  (req_query_feature_1),
      .req_query_feature_2  (req_query_feature_2),
      .req_query_feature_3  (req_query_feature_3),
      .rsp_valid            (rsp_valid),
      .rsp_best_row         (rsp_best_row),
      .rsp_best_col         (rsp_best_col),
      .rsp_best_feature_0   (rsp_best_feature_0),
      .rsp_best_feature_1   (rsp_best_feature_1),
      .rsp_best_feature_2   (rsp_best_feature_2),
      .rsp_best_feature_3   (rsp_best_feature_3),
      .rsp_best_distance_sq (rsp_best_distance_sq),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // row-major scan, strictly smaller squared distance wins
   function automatic best_match_type find_best_match(input feat_vec_type q);
      best_match_type m;
      int             side;
      longint         d;
      longint         sum;
      longint         best;
      bit             found;
      m = '0;
      best = 0;
      found = 0;
      side = int'(grid_side_cfg);
      if (side == 0) side = 1;
      if (side > GRID_MAX) side = GRID_MAX;
      for (int r = 0; r < side; r++) begin
         for (int c = 0; c < side; c++) begin
            sum = 0;
            // first above last gives an empty range and a zero sum
            for (int f = int'(first_feat_cfg); f <= int'(last_feat_cfg); f++) begin
               d = longint'($signed(q[f])) - longint'($signed(node_weight[r*GRID_MAX+c][f]));
               sum += d * d;
            end
            if (!found || sum < best) begin
               found = 1;
               best = sum;
               m.row = r[POS_FIELD_BITS-1:0];
               m.col = c[POS_FIELD_BITS-1:0];
            end
         end
      end
      m.feat = node_weight[{m.row, m.col}];
      m.dist_sq = best[DIST_BITS-1:0];
      return m;
   endfunction

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // append one expectation at the tail of the queue
   function automatic void queue_match(input best_match_type m);
      pending_matches.insert(pending_matches.size(), m);
   endfunction

   // append one row to the directed table
   function automatic void add_step(input stim_step_type s);
      dir_steps.insert(dir_steps.size(), s);
   endfunction

   // monitor: mirror config and loads, queue expectations, check results
   always @(posedge clock) begin
      best_match_type got;
      best_match_type want;
      if (reset) begin
         grid_side_cfg  = GRID_SIDE_RESET;
         first_feat_cfg = FIRST_FEATURE_RESET;
         last_feat_cfg  = LAST_FEATURE_RESET;
      end else begin
         if (rsp_valid === 1'b1) begin
            got.row     = rsp_best_row;
            got.col     = rsp_best_col;
            got.feat    = {rsp_best_feature_3, rsp_best_feature_2,
                           rsp_best_feature_1, rsp_best_feature_0};
            got.dist_sq = rsp_best_distance_sq;
            if (pending_matches.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with no query outstanding, expected none, actual %0h",
                           $time, got);
            end else begin
               want = pending_matches.pop_front();
               check_field("best_row", 64'(want.row), 64'(got.row));
               check_field("best_col", 64'(want.col), 64'(got.col));
               for (int f = 0; f < QUERY_FIELDS; f++)
                  check_field($sformatf("best_feature_%0d", f),
                              64'(want.feat[f]), 64'(got.feat[f]));
               check_field("best_distance_sq", 64'(want.dist_sq), 64'(got.dist_sq));
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            case (csr_index)
               REG_GRID_SIDE:     grid_side_cfg  = csr_wdata[SIDE_CFG_BITS-1:0];
               REG_FIRST_FEATURE: first_feat_cfg = csr_wdata[FEAT_SEL_BITS-1:0];
               REG_LAST_FEATURE:  last_feat_cfg  = csr_wdata[FEAT_SEL_BITS-1:0];
               default: ;
            endcase
         end
         if (start && busy === 1'b0) begin
            if (req_kind == KIND_LOAD)
               node_weight[{req_node_row, req_node_col}][req_weight_index] = req_weight_value;
            else if (pinned_flag)
               queue_match(pinned_match);
            else
               queue_match(find_best_match({req_query_feature_3,
                  req_query_feature_2, req_query_feature_1, req_query_feature_0}));
         end
      end
   end

   // Q8.8 value with extra weight on the ends of the range and zero
   function automatic q88_type rand_q88();
      case ($urandom_range(0, 24))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return q88_type'($urandom);
      endcase
   endfunction

   function automatic stim_step_type load_step(input logic [POS_FIELD_BITS-1:0] r,
                                               input logic [POS_FIELD_BITS-1:0] c,
                                               input logic [WIDX_BITS-1:0] w,
                                               input q88_type v);
      stim_step_type s;
      s = '{kind: STEP_LOAD, row: r, col: c, widx: w, value: v,
            query: feat_vec_type'({$urandom, $urandom}), csr_idx: '0, csr_data: '0,
            pinned: 1'b0, result: '0};
      return s;
   endfunction

   // address fields of a query word carry noise the block must ignore
   function automatic stim_step_type query_step(input feat_vec_type q, input bit pin,
                                                input best_match_type res);
      stim_step_type s;
      s = '{kind: STEP_QUERY, row: POS_FIELD_BITS'($urandom), col: POS_FIELD_BITS'($urandom),
            widx: WIDX_BITS'($urandom), value: q88_type'($urandom), query: q,
            csr_idx: '0, csr_data: '0, pinned: pin, result: res};
      return s;
   endfunction

   function automatic stim_step_type csr_step(input logic [CSR_INDEX_BITS-1:0] idx,
                                              input logic [CSR_DATA_BITS-1:0] data);
      stim_step_type s;
      s = '{kind: STEP_CSR, row: '0, col: '0, widx: '0, value: '0, query: '0,
            csr_idx: idx, csr_data: data, pinned: 1'b0, result: '0};
      return s;
   endfunction

   // hold start low until every outstanding query has answered
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_matches.size() != 0);
   endtask

   // config writes only on an idle block, after the scan has fully wound down
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   // offer one word and return at the edge that takes it
   task automatic send_word(input stim_step_type s);
      start               <= 1'b1;
      req_kind            <= (s.kind == STEP_QUERY) ? KIND_QUERY : KIND_LOAD;
      req_node_row        <= s.row;
      req_node_col        <= s.col;
      req_weight_index    <= s.widx;
      req_weight_value    <= s.value;
      req_query_feature_0 <= s.query[0];
      req_query_feature_1 <= s.query[1];
      req_query_feature_2 <= s.query[2];
      req_query_feature_3 <= s.query[3];
      pinned_flag         <= s.pinned;
      pinned_match        <= s.result;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic sender_gap();
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic run_step(input stim_step_type s);
      if (s.kind == STEP_CSR) begin
         write_reg(s.csr_idx, s.csr_data);
      end else begin
         send_word(s);
         sender_gap();
      end
   endtask

   // stimulus
   initial begin
      stim_step_type             s;
      feat_vec_type              q;
      feat_vec_type              base;
      logic [SIDE_CFG_BITS-1:0]  side_val;
      int                        side_eff;
      int                        r;
      int                        c;
      logic [WIDX_BITS-1:0]      w;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill every node so that no query ever reads an unloaded weight
      for (int n = 0; n < GRID_MAX*GRID_MAX; n++)
         for (int k = 0; k < QUERY_FIELDS; k++)
            send_word(load_step(n[7:4], n[3:0], k[1:0], rand_q88()));

      // directed table: node (0,0) at one corner of the range
      add_step(load_step(4'd0, 4'd0, 2'd0, 16'sh7FFF));
      add_step(load_step(4'd0, 4'd0, 2'd1, 16'sh8000));
      add_step(load_step(4'd0, 4'd0, 2'd2, 16'sh7FFF));
      add_step(load_step(4'd0, 4'd0, 2'd3, 16'sh8000));
      // side zero scans only node (0,0)
      add_step(csr_step(REG_GRID_SIDE, 5'd0));
      add_step(query_step(CORNER_W, 1'b1,
         '{row: 4'd0, col: 4'd0, feat: CORNER_W, dist_sq: 34'd0}));
      add_step(query_step(FAR_Q, 1'b1,
         '{row: 4'd0, col: 4'd0, feat: CORNER_W, dist_sq: 34'd17179344900}));
      add_step(csr_step(REG_SPARE, 5'd31));
      add_step(csr_step(REG_GRID_SIDE, 5'd1));
      add_step(query_step(feat_vec_type'(0), 1'b0, '0));
      // first above last: empty range, (0,0) wins at zero; upper data bits set
      add_step(csr_step(REG_FIRST_FEATURE, 5'd30));
      add_step(csr_step(REG_LAST_FEATURE, 5'd1));
      add_step(csr_step(REG_GRID_SIDE, 5'd31));
      add_step(query_step({16'hA5A5, 16'h0001, 16'hFEDC, 16'h1357}, 1'b1,
         '{row: 4'd0, col: 4'd0, feat: CORNER_W, dist_sq: 34'd0}));
      // single feature at the top index over the full grid
      add_step(csr_step(REG_FIRST_FEATURE, 5'd3));
      add_step(csr_step(REG_LAST_FEATURE, 5'd3));
      add_step(query_step({16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0));
      // tie on feature 0 between (0,1) and (1,1): the earlier node keeps it
      add_step(csr_step(REG_GRID_SIDE, 5'd2));
      add_step(csr_step(REG_FIRST_FEATURE, 5'd0));
      add_step(csr_step(REG_LAST_FEATURE, 5'd0));
      add_step(load_step(4'd0, 4'd1, 2'd0, 16'sh1234));
      add_step(load_step(4'd1, 4'd0, 2'd0, 16'sh0000));
      add_step(load_step(4'd1, 4'd1, 2'd0, 16'sh1234));
      add_step(query_step({16'h0000, 16'h0000, 16'h0000, 16'h1234}, 1'b0, '0));
      // back to full range and size, queries at both ends of the range
      add_step(csr_step(REG_LAST_FEATURE, 5'd3));
      add_step(csr_step(REG_GRID_SIDE, 5'd16));
      add_step(load_step(4'd15, 4'd15, 2'd3, 16'shFFFF));
      add_step(query_step({4{16'h8000}}, 1'b0, '0));
      add_step(query_step({4{16'h7FFF}}, 1'b0, '0));

      idle_pct = 36;
      foreach (dir_steps[i]) run_step(dir_steps[i]);

      // random phases: mostly small grids, one full and one oversized setting
      for (int ph = 0; ph < 9; ph++) begin
         idle_pct = (ph < 3) ? 36 : (ph < 6) ? 74 : 0;
         if (ph == 4)
            side_val = 5'd16;
         else if (ph == 7)
            side_val = SIDE_CFG_BITS'($urandom_range(17, 31));
         else if (ph == 1)
            side_val = 5'd0;
         else
            side_val = SIDE_CFG_BITS'($urandom_range(1, 5));
         side_eff = (side_val == 0) ? 1 : (side_val > GRID_MAX) ? GRID_MAX : int'(side_val);
         write_reg(REG_GRID_SIDE, side_val);
         write_reg(REG_FIRST_FEATURE, {3'($urandom),
            ($urandom_range(0, 99) < 70) ? 2'd0 : 2'($urandom)});
         write_reg(REG_LAST_FEATURE, {3'($urandom),
            ($urandom_range(0, 99) < 70) ? 2'd3 : 2'($urandom)});
         if (ph % 3 == 2) write_reg(REG_SPARE, 5'($urandom));

         for (int i = 0; i < 42; i++) begin
            r = $urandom_range(0, side_eff - 1);
            c = $urandom_range(0, side_eff - 1);
            base = node_weight[r*GRID_MAX+c];
            if ($urandom_range(0, 99) < 55) begin
               // query near a node in use, an exact copy, or anywhere
               case ($urandom_range(0, 4))
                  0: q = base;
                  1, 2: for (int f = 0; f < QUERY_FIELDS; f++)
                     q[f] = base[f] + q88_type'($urandom_range(0, 6)) - 16'sd3;
                  default: for (int f = 0; f < QUERY_FIELDS; f++) q[f] = rand_q88();
               endcase
               s = query_step(q, 1'b0, '0);
            end else begin
               // loads mostly inside the grid in use; copies build ties
               w = WIDX_BITS'($urandom);
               if ($urandom_range(0, 99) < 30)
                  s = load_step(4'($urandom_range(0, side_eff - 1)),
                                4'($urandom_range(0, side_eff - 1)), w, base[w]);
               else if ($urandom_range(0, 99) < 80)
                  s = load_step(4'($urandom_range(0, side_eff - 1)),
                                4'($urandom_range(0, side_eff - 1)), w, rand_q88());
               else
                  s = load_step(4'($urandom), 4'($urandom), w, rand_q88());
            end
            run_step(s);
            if ($urandom_range(0, 99) < 3) wait_drained();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_matches.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
hdl/sompbm_pkg.sv
hdl/sompbm_dist.sv
hdl/som_partial_best_match_query.sv
dv/som_partial_best_match_query_tb.sv
